// File: sv/frobenius_norm_engine_top_defines.svh
// assertion macros for the frobenius norm engine
`ifndef FROBENIUS_NORM_ENGINE_TOP_DEFINES_SVH
`define FROBENIUS_NORM_ENGINE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// plain clocked property, disabled during reset
`define FNE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define FNE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FNE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FNE_ASSERT(lbl, prop, msg)
`define FNE_ASSERT_IMPL(lbl, ante, cons, msg)
`define FNE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/fne_pkg.sv
// shared types and constants for the frobenius norm engine
`timescale 1ns / 1ps

package fne_pkg;

    // default configuration
    localparam int ELEMENT_BITS_DEF = 16;
    localparam int ACCUM_BITS_DEF   = 50;
    localparam int FRAC_BITS_DEF    = 8;

    // fixed result field widths
    localparam int NORM_BITS = 33;
    localparam int SUM_BITS  = 50;

    // controller states
    typedef enum logic {
        S_ACC,
        S_ROOT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic sq_load;
        logic acc_en;
        logic root_load;
        logic root_step;
        logic out_load;
    } t_dp_cmd;

endpackage

// File: sv/fne_if.sv
// valid/ready channel interfaces for elements and results
`timescale 1ns / 1ps

interface fne_in_if #(
    parameter int ELEMENT_BITS = fne_pkg::ELEMENT_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [ELEMENT_BITS-1:0] element;
    logic                           last;

    modport source (output valid, output element, output last, input ready);
    modport sink   (input valid, input element, input last, output ready);
endinterface

interface fne_out_if;
    import fne_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [NORM_BITS-1:0] norm;
    logic [SUM_BITS-1:0]  sum_of_squares;
    logic                 saturated;

    modport source (output valid, output norm, output sum_of_squares, output saturated,
                    input ready);
    modport sink   (input valid, input norm, input sum_of_squares, input saturated,
                    output ready);
endinterface

// File: sv/frobenius_norm_engine_top.sv
// top level of the frobenius norm engine
//
//  channel  | dir | fields                              | transfer
//  ---------+-----+-------------------------------------+-------------------
//  i_elem   | in  | element, last                       | valid && ready
//  o_res    | out | norm, sum_of_squares, saturated     | valid && ready
//
//  elements stream at one per cycle through a squarer register and the accumulator while
//  no last element is held in the squarer stage; ROOT_BITS = (ACCUM_BITS + 2*FRAC_BITS + 1)/2
//  (33 by default) root bits are resolved, one root bit per cycle; elements of the next
//  matrix accumulate while the root runs
//  the next last element waits in the squarer stage until the root unit has loaded the
//  result register, which in turn waits for the previous result to transfer
//  synchronous active-low reset clears accumulator, flag and all handshake state
`timescale 1ns / 1ps
`include "frobenius_norm_engine_top_defines.svh"

module frobenius_norm_engine_top #(
    parameter int ELEMENT_BITS = fne_pkg::ELEMENT_BITS_DEF,
    parameter int ACCUM_BITS   = fne_pkg::ACCUM_BITS_DEF,
    parameter int FRAC_BITS    = fne_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fne_in_if.sink    i_elem,
    fne_out_if.source o_res
);
    import fne_pkg::*;

    localparam int ROOT_BITS = (ACCUM_BITS + 2 * FRAC_BITS + 1) / 2;

    t_dp_cmd s_cmd;
    logic    s_in_ready;
    logic    s_out_valid;

    // controller
    fne_ctrl #(
        .ROOT_BITS (ROOT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_elem.valid),
        .i_in_last   (i_elem.last),
        .o_in_ready  (s_in_ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (s_out_valid),
        .o_cmd       (s_cmd)
    );

    // datapath
    fne_datapath #(
        .ELEMENT_BITS (ELEMENT_BITS),
        .ACCUM_BITS   (ACCUM_BITS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_cmd),
        .i_element        (i_elem.element),
        .o_norm           (o_res.norm),
        .o_sum_of_squares (o_res.sum_of_squares),
        .o_saturated      (o_res.saturated)
    );

    // handshake outputs
    assign i_elem.ready = s_in_ready;
    assign o_res.valid  = s_out_valid;

    // checks
    `FNE_ASSERT_IMPL(a_no_overwrite, s_cmd.out_load, !s_out_valid || o_res.ready, "lost result")
    `FNE_ASSERT_NEXT(a_one_shot, s_out_valid && o_res.ready && !s_cmd.out_load, !s_out_valid, "repeat")
    `FNE_ASSERT_IMPL(a_root_load_accum, s_cmd.root_load, s_cmd.acc_en, "last not accumulated")
    `FNE_ASSERT(a_root_out_excl, !(s_cmd.root_load && s_cmd.out_load), "root and result load")

endmodule

// File: sv/fne_ctrl.sv
// controller: product stage tracking, root sequencing and result handshake
`timescale 1ns / 1ps

module fne_ctrl #(
    parameter int ROOT_BITS = (fne_pkg::ACCUM_BITS_DEF + 2 * fne_pkg::FRAC_BITS_DEF + 1) / 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output fne_pkg::t_dp_cmd o_cmd
);
    import fne_pkg::*;

    localparam int CW = $clog2(ROOT_BITS + 1);

    t_state        r_state, n_state;
    logic          r_sq_valid, n_sq_valid;
    logic          r_sq_last, n_sq_last;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;

    logic in_xfer;
    logic root_done;
    logic out_free;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_sq_valid  <= 1'b0;
            r_sq_last   <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sq_valid  <= n_sq_valid;
            r_sq_last   <= n_sq_last;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        // a last element in the product stage blocks new transfers until it is consumed
        o_in_ready = !(r_sq_valid && r_sq_last);
        in_xfer    = i_in_valid && o_in_ready;
        root_done  = (r_state == S_ROOT) && (r_cnt == '0);
        out_free   = !r_out_valid || i_out_ready;

        o_cmd           = '0;
        o_cmd.sq_load   = in_xfer;
        o_cmd.acc_en    = r_sq_valid && (!r_sq_last || (r_state == S_ACC));
        o_cmd.root_load = r_sq_valid && r_sq_last && (r_state == S_ACC);
        o_cmd.root_step = (r_state == S_ROOT) && (r_cnt != '0);
        o_cmd.out_load  = root_done && out_free;

        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_ACC: begin
                if (o_cmd.root_load) begin
                    n_state = S_ROOT;
                    n_cnt   = CW'(ROOT_BITS);
                end
            end
            S_ROOT: begin
                if (o_cmd.root_step) begin
                    n_cnt = r_cnt - CW'(1);
                end
                if (o_cmd.out_load) begin
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase

        // product stage occupancy
        if (in_xfer) begin
            n_sq_valid = 1'b1;
            n_sq_last  = i_in_last;
        end else begin
            n_sq_valid = o_cmd.acc_en ? 1'b0 : r_sq_valid;
            n_sq_last  = r_sq_last;
        end

        // result register occupancy
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: sv/fne_datapath.sv
// datapath: squarer, saturating accumulator, bit-serial square root, result register
`timescale 1ns / 1ps

module fne_datapath #(
    parameter int ELEMENT_BITS = fne_pkg::ELEMENT_BITS_DEF,
    parameter int ACCUM_BITS   = fne_pkg::ACCUM_BITS_DEF,
    parameter int FRAC_BITS    = fne_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fne_pkg::t_dp_cmd                i_cmd,
    input  logic signed [ELEMENT_BITS-1:0]  i_element,
    output logic [fne_pkg::NORM_BITS-1:0]   o_norm,
    output logic [fne_pkg::SUM_BITS-1:0]    o_sum_of_squares,
    output logic                            o_saturated
);
    import fne_pkg::*;

    localparam int EB = ELEMENT_BITS;
    localparam int AB = ACCUM_BITS;
    localparam int SB = 2 * ELEMENT_BITS;
    localparam int RB = (ACCUM_BITS + 2 * FRAC_BITS + 1) / 2;
    localparam int XW = 2 * RB;
    localparam int RW = RB + 2;
    localparam int SW = ((SB > AB) ? SB : AB) + 1;
    localparam logic [SW-1:0] ACC_MAX_W = SW'({AB{1'b1}});

    logic [EB-1:0] w_mag;
    logic [SW-1:0] w_total;
    logic          w_over;
    logic [AB-1:0] w_acc_next;
    logic          w_sat_next;
    logic [RW-1:0] w_rem_sh;
    logic [RW-1:0] w_trial;
    logic [63:0]   w_root_ext;
    logic [64:0]   w_sum_ext;

    logic [SB-1:0] r_sq;
    logic [AB-1:0] r_acc;
    logic          r_sat;
    logic [AB-1:0] r_res_sum;
    logic          r_res_sat;
    logic [XW-1:0] r_x;
    logic [RW-1:0] r_rem;
    logic [RB-1:0] r_root;
    logic [NORM_BITS-1:0] r_norm;
    logic [SUM_BITS-1:0]  r_sum;
    logic                 r_sat_out;

    // magnitude; the most negative code maps to its full positive value
    assign w_mag = i_element[EB-1] ? EB'(~$unsigned(i_element) + EB'(1)) : $unsigned(i_element);

    // square register
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_load) begin
            r_sq <= SB'(w_mag) * SB'(w_mag);
        end
    end

    // saturating add
    assign w_total    = SW'(r_acc) + SW'(r_sq);
    assign w_over     = (w_total > ACC_MAX_W);
    assign w_acc_next = w_over ? {AB{1'b1}} : w_total[AB-1:0];
    assign w_sat_next = r_sat | w_over;

    // accumulator and saturation flag, cleared when the matrix closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (i_cmd.root_load) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (i_cmd.acc_en) begin
            r_acc <= w_acc_next;
            r_sat <= w_sat_next;
        end
    end

    // one root bit per step: bring down two radicand bits, try 4*root+1
    assign w_rem_sh = {r_rem[RB-1:0], r_x[XW-1:XW-2]};
    assign w_trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_load) begin
            r_res_sum <= w_acc_next;
            r_res_sat <= w_sat_next;
            r_x       <= XW'(w_acc_next) << (2 * FRAC_BITS);
            r_rem     <= '0;
            r_root    <= '0;
        end else if (i_cmd.root_step) begin
            r_x <= r_x << 2;
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[RB-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[RB-2:0], 1'b0};
            end
        end
    end

    // fit root and sum to the result field widths
    assign w_root_ext = 64'(r_root);
    assign w_sum_ext  = 65'(r_res_sum);

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_norm    <= w_root_ext[NORM_BITS-1:0];
            r_sum     <= w_sum_ext[SUM_BITS-1:0];
            r_sat_out <= r_res_sat;
        end
    end

    assign o_norm           = r_norm;
    assign o_sum_of_squares = r_sum;
    assign o_saturated      = r_sat_out;

endmodule

// File: bench/frobenius_norm_engine_checker.sv
// checker for the frobenius norm engine: predicts each matrix result and compares transfers
`timescale 1ns / 1ps

module frobenius_norm_engine_checker #(
    parameter int ELEMENT_BITS = fne_pkg::ELEMENT_BITS_DEF,
    parameter int ACCUM_BITS   = fne_pkg::ACCUM_BITS_DEF,
    parameter int FRAC_BITS    = fne_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fne_in_if    i_elem,
    fne_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import fne_pkg::*;

    // one predicted result per matrix
    typedef struct packed {
        logic [NORM_BITS-1:0] norm;
        logic [SUM_BITS-1:0]  sum_of_squares;
        logic                 saturated;
    } matrix_result_t;

    localparam logic [63:0] SUM_CEILING = (64'd1 << ACCUM_BITS) - 64'd1;

    matrix_result_t matrix_results_q[$];
    logic [63:0]    running_sum;
    logic           sum_clipped;
    int             mismatches;

    always @(posedge i_clk) begin
        matrix_result_t want;
        logic [63:0]    elem_wide;
        logic [63:0]    elem_square;
        logic [95:0]    scaled;
        logic [47:0]    root;
        logic [47:0]    trial;
        if (!i_rst_n) begin
            matrix_results_q.delete();
            running_sum = '0;
            sum_clipped = 1'b0;
            mismatches  = 0;
        end else begin
            // result transfer: compare against the oldest open matrix
            if (i_res.valid && i_res.ready) begin
                if (matrix_results_q.size() == 0) begin
                    $error("result transfer with no matrix outstanding");
                    mismatches++;
                end else begin
                    want = matrix_results_q.pop_front();
                    if (i_res.norm !== want.norm) begin
                        $error("norm mismatch: expected %0d, actual %0d", want.norm, i_res.norm);
                        mismatches++;
                    end
                    if (i_res.sum_of_squares !== want.sum_of_squares) begin
                        $error("sum_of_squares mismatch: expected %0d, actual %0d",
                               want.sum_of_squares, i_res.sum_of_squares);
                        mismatches++;
                    end
                    if (i_res.saturated !== want.saturated) begin
                        $error("saturated mismatch: expected %0d, actual %0d",
                               want.saturated, i_res.saturated);
                        mismatches++;
                    end
                end
            end

            // element transfer: square and accumulate, clipping at the accumulator ceiling
            if (i_elem.valid && i_elem.ready) begin
                elem_wide   = 64'($signed(i_elem.element));
                if (elem_wide[63])
                    elem_wide = -elem_wide;
                elem_square = elem_wide * elem_wide;
                if (elem_square > SUM_CEILING || running_sum > SUM_CEILING - elem_square) begin
                    running_sum = SUM_CEILING;
                    sum_clipped = 1'b1;
                end else begin
                    running_sum = running_sum + elem_square;
                end

                // last element closes the matrix: floor root of the scaled sum
                if (i_elem.last) begin
                    scaled = 96'(running_sum) << (2 * FRAC_BITS);
                    root   = '0;
                    for (int b = 47; b >= 0; b--) begin
                        trial = root | (48'd1 << b);
                        if ({48'd0, trial} * {48'd0, trial} <= scaled)
                            root = trial;
                    end
                    want.norm           = root[NORM_BITS-1:0];
                    want.sum_of_squares = running_sum[SUM_BITS-1:0];
                    want.saturated      = sum_clipped;
                    matrix_results_q.push_back(want);
                    running_sum = '0;
                    sum_clipped = 1'b0;
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= matrix_results_q.size();
    end

endmodule

// File: bench/frobenius_norm_engine_top_tb.sv
// stimulus, watchdog and verdict for the frobenius norm engine
`timescale 1ns / 1ps

module frobenius_norm_engine_top_tb;
    import fne_pkg::*;

    localparam int EW          = ELEMENT_BITS_DEF;
    localparam int PHASE_ELEMS = 630;
    localparam int STALL_LIMIT = 4000;

    typedef logic signed [EW-1:0] elem_t;

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   elem_count;
    int   matrix_count;
    int   quiet_cycles;
    int   fail_count;
    int   open_matrices;

    fne_in_if #(.ELEMENT_BITS(EW)) elem_ch ();
    fne_out_if                     res_ch ();

    frobenius_norm_engine_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_elem  (elem_ch),
        .o_res   (res_ch)
    );

    frobenius_norm_engine_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_elem       (elem_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (open_matrices)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side back-pressure
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else if ((elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one element transfer, with random idle cycles ahead of it
    task automatic send_elem(input elem_t value, input logic is_last);
        while ($urandom_range(99) < src_idle_pct) begin
            elem_ch.valid   <= 1'b0;
            elem_ch.element <= elem_t'($urandom);
            elem_ch.last    <= 1'($urandom_range(1));
            @(negedge clk);
        end
        elem_ch.valid   <= 1'b1;
        elem_ch.element <= value;
        elem_ch.last    <= is_last;
        do @(posedge clk); while (!elem_ch.ready);
        @(negedge clk);
        elem_count++;
        if (is_last)
            matrix_count++;
    endtask

    task automatic send_matrix(input elem_t vals[$]);
        foreach (vals[k])
            send_elem(vals[k], k == vals.size() - 1);
    endtask

    // hold the element side until every open matrix has reported
    task automatic drain_results();
        elem_ch.valid <= 1'b0;
        do @(negedge clk); while (open_matrices != 0);
    endtask

    // random matrices, mostly short, with one full drain halfway through
    task automatic run_random(input int quota);
        int    first;
        int    len;
        bit    drained;
        elem_t v;
        first   = elem_count;
        drained = 1'b0;
        while (elem_count - first < quota) begin
            if (!drained && elem_count - first >= quota / 2) begin
                drain_results();
                drained = 1'b1;
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(9)) inside
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7FFF;
                    2:       v = 16'sh8001;
                    [3:4]:   v = elem_t'(int'($urandom_range(16)) - 8);
                    default: v = elem_t'($urandom);
                endcase
                send_elem(v, k == len - 1);
            end
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        elem_ch.valid   = 1'b0;
        elem_ch.element = '0;
        elem_ch.last    = 1'b0;
        src_idle_pct    = 20;
        sink_stall_pct  = 47;
        elem_count      = 0;
        matrix_count    = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero, extremes, single-element matrices, alternating bits
        send_matrix('{16'sh0000});
        send_matrix('{16'sh8000});
        send_matrix('{16'sh7FFF});
        send_matrix('{16'sh0001});
        send_matrix('{16'shFFFF});
        send_matrix('{16'sh0003, 16'sh0004});
        send_matrix('{16'sh5555, 16'shAAAA});
        send_matrix('{16'sh8000, 16'sh7FFF, 16'sh8001, 16'sh0000, 16'sh0001, 16'shFFFE});
        send_matrix('{16'sh0000, 16'sh0000, 16'sh0000});
        drain_results();

        // random traffic under three idle mixes
        run_random(PHASE_ELEMS);
        drain_results();
        src_idle_pct   = 47;
        sink_stall_pct = 20;
        run_random(PHASE_ELEMS);
        drain_results();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random(PHASE_ELEMS);

        // short tail straight after the back-to-back phase
        send_matrix('{16'sh0002, 16'shFFFD});
        run_random(40);

        elem_ch.valid <= 1'b0;
        do @(negedge clk); while (open_matrices != 0);
        repeat (64) @(negedge clk);

        $display("run covered %0d element transfers in %0d matrices over three idle mixes",
                 elem_count, matrix_count);
        $display("including directed extremes, one-element matrices and full result drains");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/fne_pkg.sv
sv/fne_if.sv
sv/fne_ctrl.sv
sv/fne_datapath.sv
sv/frobenius_norm_engine_top.sv
bench/frobenius_norm_engine_checker.sv
bench/frobenius_norm_engine_top_tb.sv
